// ===== rtl/gcs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcs_pkg
// shared constants and types of the 3d gaussian curve smoother
// ----------------------------------------------------------------------------
package gcs_pkg;
  localparam int MaxPoints = 64;
  localparam int AddrW = 6;
  localparam int CountW = 7;

  localparam logic [2:0] RegWc = 3'd0;
  localparam logic [2:0] RegW1 = 3'd1;
  localparam logic [2:0] RegW2 = 3'd2;
  localparam logic [2:0] RegW3 = 3'd3;
  localparam logic [2:0] RegLim = 3'd4;
  localparam logic [2:0] RegLimEn = 3'd5;
  localparam logic [2:0] RegZOnly = 3'd6;
  localparam logic [2:0] RegPass = 3'd7;

  // divider request and answer between sequencer and divider
  typedef struct packed {
    logic start;
    logic signed [63:0] num;
    logic [18:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic signed [31:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/gaussian_curve_smoother_3d.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_curve_smoother_3d
// loads a 3d curve, smooths it over several passes, emits it
// ----------------------------------------------------------------------------
// loading: one beat a cycle; the last point starts the pad fetch of head and tail.
// per point and pass: a centre read, seven taps (address, read, three axis
// squares, accumulate), a serial division per smoothed axis and a write;
// with z only one axis is divided, and a zero weight sum skips the division;
// the shared divider sets the rate. emission: one beat a cycle while out_stall
// is low, after a read state. synchronous reset restores register defaults.
module gaussian_curve_smoother_3d (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  input  wire logic is_last,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic out_last,
  output logic overflow,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam logic [3:0] SLoad = 4'd0, SPad = 4'd1, SCtr = 4'd2, SCtrW = 4'd3,
    STap = 4'd4, STapW = 4'd5, STapS = 4'd6, STapA = 4'd7, SDiv = 4'd8,
    SDivW = 4'd9, SWr = 4'd10, SOutR = 4'd11, SOut = 4'd12;

  logic [15:0] wc, w1, w2, w3;
  logic [31:0] lim;
  logic lim_en, z_only;
  logic [9:0] passes;

  logic signed [31:0] mem_x [gcs_pkg::MaxPoints];
  logic signed [31:0] mem_y [gcs_pkg::MaxPoints];
  logic signed [31:0] mem_z [gcs_pkg::MaxPoints];
  logic signed [31:0] rd_x, rd_y, rd_z;
  logic [gcs_pkg::AddrW-1:0] rd_addr;

  logic [3:0] state;
  logic [gcs_pkg::CountW-1:0] count;
  logic dropped;
  logic signed [31:0] hx, hy, hz, tx, ty, tz, cx, cy, cz, px, py, pz;
  logic [9:0] pass;
  logic [gcs_pkg::AddrW-1:0] idx;
  logic [2:0] tap;
  logic [1:0] axis;
  logic signed [63:0] sx, sy, sz;
  logic [18:0] sw;
  logic signed [31:0] qx, qy, qz;
  logic [65:0] sq_sum;
  logic [1:0] sq_ax;
  logic [32:0] dabs;
  logic [65:0] lim2;
  logic src_head, src_tail;
  logic signed [7:0] pos;
  logic [15:0] tw;
  logic [3:0] tap_state;

  gcs_pkg::div_req_t dreq;
  gcs_pkg::div_rsp_t drsp;

  gcs_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign cfg_ready = (state == SLoad);
  assign in_stall = (state != SLoad);
  assign out_valid = (state == SOut);
  assign out_x = rd_x;
  assign out_y = rd_y;
  assign out_z = rd_z;
  assign out_last = ({1'b0, idx} == count - 7'd1);
  assign overflow = dropped;

  assign pos = 8'($signed({2'b0, idx})) + 8'($signed({5'b0, tap})) - 8'sd3;

  always_comb begin
    case (tap)
      3'd3: tw = wc;
      3'd2, 3'd4: tw = w1;
      3'd1, 3'd5: tw = w2;
      default: tw = w3;
    endcase
  end

  // memory read, registered
  always_ff @(posedge clk) begin
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
    rd_z <= mem_z[rd_addr];
    if (state == SLoad && in_valid && count < 7'(gcs_pkg::MaxPoints)) begin
      mem_x[count[gcs_pkg::AddrW-1:0]] <= point_x;
      mem_y[count[gcs_pkg::AddrW-1:0]] <= point_y;
      mem_z[count[gcs_pkg::AddrW-1:0]] <= point_z;
    end else if (state == SWr) begin
      mem_z[idx] <= qz;
      if (!z_only) begin
        mem_x[idx] <= qx;
        mem_y[idx] <= qy;
      end
    end
  end

  always_comb begin
    rd_addr = idx;
    case (state)
      SPad: rd_addr = tap[0] ? 6'(count - 7'd1) : '0;
      STap: rd_addr = pos[gcs_pkg::AddrW-1:0];
      SOutR: rd_addr = idx;
      SOut: rd_addr = out_stall ? idx : idx + 6'd1;
      default: rd_addr = idx;
    endcase
  end

  // squared distance, one axis a cycle on the shared path
  always_comb begin
    case (sq_ax)
      2'd0: dabs = 33'($signed({px[31], px}) - $signed({cx[31], cx}));
      2'd1: dabs = 33'($signed({py[31], py}) - $signed({cy[31], cy}));
      default: dabs = 33'($signed({pz[31], pz}) - $signed({cz[31], cz}));
    endcase
    if (dabs[32]) dabs = 33'(-dabs);
  end
  assign lim2 = {2'b0, {32'b0, lim} * {32'b0, lim}};

  always_comb begin
    dreq.start = (state == SDiv) && (sw != '0);
    dreq.den = sw;
    case (axis)
      2'd0: dreq.num = sx;
      2'd1: dreq.num = sy;
      default: dreq.num = sz;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SLoad;
      count <= '0;
      dropped <= 1'b0;
      wc <= 16'd26000; w1 <= 16'd16000; w2 <= 16'd4000; w3 <= 16'd300;
      lim <= 32'd65536; lim_en <= 1'b0; z_only <= 1'b0; passes <= 10'd1;
      hx <= '0; hy <= '0; hz <= '0; tx <= '0; ty <= '0; tz <= '0;
      idx <= '0; tap <= '0; pass <= '0; axis <= '0; sq_ax <= '0;
      tap_state <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gcs_pkg::RegWc: wc <= cfg_data[15:0];
          gcs_pkg::RegW1: w1 <= cfg_data[15:0];
          gcs_pkg::RegW2: w2 <= cfg_data[15:0];
          gcs_pkg::RegW3: w3 <= cfg_data[15:0];
          gcs_pkg::RegLim: lim <= cfg_data;
          gcs_pkg::RegLimEn: lim_en <= cfg_data[0];
          gcs_pkg::RegZOnly: z_only <= cfg_data[0];
          gcs_pkg::RegPass: passes <= cfg_data[9:0];
          default: ;
        endcase
      end
      case (state)
        SLoad: if (in_valid) begin
          if (count < 7'(gcs_pkg::MaxPoints)) count <= count + 7'd1;
          else dropped <= 1'b1;
          if (is_last) begin
            state <= SPad;
            tap <= '0;
            tap_state <= '0;
          end
        end
        SPad: begin
          // reads head, then tail, latching each as its registered read returns
          tap_state <= tap_state + 4'd1;
          tap <= 3'd1;
          if (tap_state == 4'd1) begin
            hx <= rd_x; hy <= rd_y; hz <= rd_z;
          end
          if (tap_state == 4'd2) begin
            tx <= rd_x; ty <= rd_y; tz <= rd_z;
            pass <= '0;
            idx <= '0;
            state <= (passes == 10'd0) ? SOutR : SCtr;
          end
        end
        SCtr: state <= SCtrW;
        SCtrW: begin
          cx <= rd_x; cy <= rd_y; cz <= rd_z;
          sx <= '0; sy <= '0; sz <= '0; sw <= '0;
          tap <= '0;
          state <= STap;
        end
        STap: begin
          src_head <= pos < 0;
          src_tail <= pos >= $signed({1'b0, count});
          state <= STapW;
        end
        STapW: begin
          px <= src_head ? hx : src_tail ? tx : rd_x;
          py <= src_head ? hy : src_tail ? ty : rd_y;
          pz <= src_head ? hz : src_tail ? tz : rd_z;
          sq_sum <= '0;
          sq_ax <= '0;
          state <= STapS;
        end
        STapS: begin
          sq_sum <= sq_sum + {2'b0, {32'b0, dabs[31:0]} * {32'b0, dabs[31:0]}};
          sq_ax <= sq_ax + 2'd1;
          if (sq_ax == 2'd2) state <= STapA;
        end
        STapA: begin
          if (!lim_en || tap == 3'd3 || sq_sum <= lim2) begin
            sw <= sw + 19'(tw);
            sx <= sx + 64'($signed({1'b0, tw}) * px);
            sy <= sy + 64'($signed({1'b0, tw}) * py);
            sz <= sz + 64'($signed({1'b0, tw}) * pz);
          end
          if (tap == 3'd6) begin
            axis <= z_only ? 2'd2 : 2'd0;
            state <= SDiv;
          end else begin
            tap <= tap + 3'd1;
            state <= STap;
          end
        end
        SDiv: begin
          // no weight used: the point keeps its value
          if (sw == '0) begin
            qx <= cx; qy <= cy; qz <= cz;
            state <= SWr;
          end else state <= SDivW;
        end
        SDivW: if (drsp.done) begin
          case (axis)
            2'd0: qx <= drsp.quo;
            2'd1: qy <= drsp.quo;
            default: qz <= drsp.quo;
          endcase
          if (axis == 2'd2) state <= SWr;
          else begin
            axis <= axis + 2'd1;
            state <= SDiv;
          end
        end
        SWr: begin
          state <= SCtr;
          if ({1'b0, idx} == count - 7'd1) begin
            idx <= '0;
            if (pass == passes - 10'd1) state <= SOutR;
            else pass <= pass + 10'd1;
          end else idx <= idx + 6'd1;
        end
        SOutR: state <= SOut;
        default: if (!out_stall) begin
          if (out_last) begin
            state <= SLoad;
            count <= '0;
            dropped <= 1'b0;
            idx <= '0;
          end else idx <= idx + 6'd1;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/gcs_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcs_div
// restoring divider, one quotient bit a cycle, truncates toward zero
// ----------------------------------------------------------------------------
module gcs_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire gcs_pkg::div_req_t req,
  output gcs_pkg::div_rsp_t rsp
);
  logic [63:0] quo;
  logic [18:0] rem;
  logic [18:0] den;
  logic neg;
  logic busy;
  logic done;
  logic [6:0] cnt;
  logic [19:0] trial;
  logic [63:0] mag;

  assign mag = req.num[63] ? 64'(-req.num) : 64'(req.num);
  assign trial = {rem, quo[63]} - {1'b0, den};
  assign rsp = {done, (neg ? 32'(-quo) : quo[31:0])};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      quo <= mag;
      rem <= '0;
      den <= req.den;
      neg <= req.num[63];
      cnt <= 7'd0;
    end else if (busy) begin
      if (!trial[19]) begin
        rem <= trial[18:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[17:0], quo[63]};
        quo <= {quo[62:0], 1'b0};
      end
      cnt <= cnt + 7'd1;
      if (cnt == 7'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== test/gcs_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcs_checker
// watches the point, result and register channels of the curve smoother,
// predicts each smoothed curve and compares it beat by beat
// ----------------------------------------------------------------------------
module gcs_checker (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_stall,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  input  wire logic is_last,
  input  wire logic out_valid,
  input  wire logic out_stall,
  input  wire logic signed [31:0] out_x,
  input  wire logic signed [31:0] out_y,
  input  wire logic signed [31:0] out_z,
  input  wire logic out_last,
  input  wire logic overflow,
  input  wire logic cfg_valid,
  input  wire logic cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  output int errors,
  output int pending
);
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic last;
    logic ovf;
  } smooth_pt_t;

  smooth_pt_t smoothed_q[$];
  logic [15:0] wt[4];
  logic [31:0] dist_lim;
  logic lim_en, zo;
  logic [9:0] passes;
  logic signed [31:0] cx[gcs_pkg::MaxPoints], cy[gcs_pkg::MaxPoints];
  logic signed [31:0] cz[gcs_pkg::MaxPoints];
  logic signed [31:0] hx, hy, hz, tx, ty, tz;
  int npts;
  logic dropped;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic point_at(input int k, output logic signed [31:0] x, y, z);
    if (k < 0) begin
      x = hx; y = hy; z = hz;
    end else if (k >= npts) begin
      x = tx; y = ty; z = tz;
    end else begin
      x = cx[k]; y = cy[k]; z = cz[k];
    end
  endtask

  function automatic logic [65:0] sq_dist(input logic signed [31:0] ax, ay, az, bx, by, bz);
    logic signed [65:0] dx, dy, dz;
    dx = ax - bx; dy = ay - by; dz = az - bz;
    return 66'(dx * dx) + 66'(dy * dy) + 66'(dz * dz);
  endfunction

  task automatic smooth_one(input int i);
    logic signed [31:0] px, py, pz, ox, oy, oz;
    longint sx, sy, sz, sw, w;
    logic [65:0] lim2;
    sx = 0; sy = 0; sz = 0; sw = 0;
    lim2 = 66'(dist_lim) * 66'(dist_lim);
    point_at(i, ox, oy, oz);
    for (int off = -3; off <= 3; off++) begin
      point_at(i + off, px, py, pz);
      if (!(lim_en && sq_dist(px, py, pz, ox, oy, oz) > lim2)) begin
        w = longint'(wt[off < 0 ? -off : off]);
        sw += w; sx += w * px; sy += w * py; sz += w * pz;
      end
    end
    if (sw != 0) begin
      cz[i] = 32'(sz / sw);
      if (!zo) begin
        cx[i] = 32'(sx / sw);
        cy[i] = 32'(sy / sw);
      end
    end
  endtask

  task automatic close_curve();
    smooth_pt_t p;
    hx = cx[0]; hy = cy[0]; hz = cz[0];
    tx = cx[npts-1]; ty = cy[npts-1]; tz = cz[npts-1];
    for (int s = 0; s < passes; s++)
      for (int i = 0; i < npts; i++) smooth_one(i);
    for (int i = 0; i < npts; i++) begin
      p.x = cx[i]; p.y = cy[i]; p.z = cz[i];
      p.last = (i == npts - 1); p.ovf = dropped;
      smoothed_q = {smoothed_q, p};
    end
    npts = 0; dropped = 0;
  endtask

  always @(posedge clk) begin
    smooth_pt_t e;
    if (rst) begin
      wt[0] = 16'd26000; wt[1] = 16'd16000; wt[2] = 16'd4000; wt[3] = 16'd300;
      dist_lim = 32'd65536; lim_en = 1'b0; zo = 1'b0; passes = 10'd1;
      npts = 0; dropped = 0; errors = 0;
      hx = 0; hy = 0; hz = 0; tx = 0; ty = 0; tz = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gcs_pkg::RegWc:    wt[0] = cfg_data[15:0];
          gcs_pkg::RegW1:    wt[1] = cfg_data[15:0];
          gcs_pkg::RegW2:    wt[2] = cfg_data[15:0];
          gcs_pkg::RegW3:    wt[3] = cfg_data[15:0];
          gcs_pkg::RegLim:   dist_lim = cfg_data;
          gcs_pkg::RegLimEn: lim_en = cfg_data[0];
          gcs_pkg::RegZOnly: zo = cfg_data[0];
          gcs_pkg::RegPass:  passes = cfg_data[9:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (npts < gcs_pkg::MaxPoints) begin
          cx[npts] = point_x; cy[npts] = point_y; cz[npts] = point_z;
          npts++;
        end else begin
          dropped = 1;
        end
        if (is_last) close_curve();
      end
      if (out_valid && !out_stall) begin
        if (smoothed_q.size() == 0) begin
          $display("unexpected result beat at %0t", $realtime);
          errors++;
        end else begin
          e = smoothed_q.pop_front();
          if (out_x !== e.x) report("out_x", out_x, e.x);
          if (out_y !== e.y) report("out_y", out_y, e.y);
          if (out_z !== e.z) report("out_z", out_z, e.z);
          if (out_last !== e.last) report("out_last", 32'(out_last), 32'(e.last));
          if (overflow !== e.ovf) report("overflow", 32'(overflow), 32'(e.ovf));
        end
      end
    end
    pending = smoothed_q.size();
  end
endmodule
`default_nettype wire

// ===== test/tb_gaussian_curve_smoother_3d.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_gaussian_curve_smoother_3d
// drives curves of random and edge-case points through the smoother under
// several kernel settings, with random gaps and stalls; a checker predicts
// and compares every emitted beat
// ----------------------------------------------------------------------------
module tb_gaussian_curve_smoother_3d;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic is_last = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_stall, out_valid, out_last, overflow, cfg_ready;
  logic signed [31:0] out_x, out_y, out_z;
  int errors, pending;
  int cycles = 0;
  int items_sent = 0;
  bit long_hold = 1'b0;
  bit stall_free = 1'b0;
  logic [9:0] cur_passes = 10'd1;

  localparam int CycleLimit = 6000000;

  always #5 clk = ~clk;

  gaussian_curve_smoother_3d u_top (.*);

  gcs_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("gaussian_curve_smoother_3d verification failed");
      $finish;
    end
  end

  // receiver stall pattern: short random stalls, the odd long one
  always @(posedge clk) begin
    if (long_hold) begin
      out_stall <= 1'b1;
    end else if (stall_free) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 99) < 3) begin
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 30) begin
      out_stall <= ~out_stall;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // valid drops only when a real gap follows
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n != 0) in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_point(input logic [31:0] x, y, z, input logic lst, input bit gap);
    cfg_valid <= 1'b0;
    if (gap) idle_gap();
    in_valid <= 1'b1;
    point_x <= x; point_y <= y; point_z <= z; is_last <= lst;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == gcs_pkg::RegPass) cur_passes = val[9:0];
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      default: return 32'($signed($urandom_range(0, 400000)) - 200000);
    endcase
  endfunction

  task automatic send_curve(input int len, input int mode);
    for (int i = 0; i < len; i++)
      send_point(rand_coord(mode), rand_coord(mode), rand_coord(mode), i == len - 1, 1'b1);
  endtask

  task automatic random_config(input bit keep_short);
    write_reg(gcs_pkg::RegWc, $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 1) * 65535)
                                                       : $urandom_range(0, 65535));
    write_reg(gcs_pkg::RegW1, $urandom_range(0, 65535));
    write_reg(gcs_pkg::RegW2, $urandom_range(0, 65535));
    write_reg(gcs_pkg::RegW3, $urandom_range(0, 65535));
    write_reg(gcs_pkg::RegLim,
              $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 3 << 16));
    write_reg(gcs_pkg::RegLimEn, $urandom_range(0, 1));
    write_reg(gcs_pkg::RegZOnly, $urandom_range(0, 1));
    write_reg(gcs_pkg::RegPass, keep_short ? $urandom_range(0, 3) : $urandom_range(0, 6));
  endtask

  initial begin
    int len;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes with reset kernel: single point, then full-scale curve
    send_point(32'h7fffffff, 32'h80000000, 32'h00000000, 1'b1, 1'b0);
    send_point(32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b0, 1'b0);
    send_point(32'h7fffffff, 32'h80000000, 32'h00000001, 1'b0, 1'b0);
    send_point(32'h80000000, 32'h7fffffff, 32'h55555555, 1'b1, 1'b0);
    drain();

    // threshold on, z only, max weights but w2 zero, one pass
    write_reg(gcs_pkg::RegLimEn, 32'd1);
    write_reg(gcs_pkg::RegLim, 32'h00010000);
    write_reg(gcs_pkg::RegZOnly, 32'd1);
    write_reg(gcs_pkg::RegWc, 32'd65535);
    write_reg(gcs_pkg::RegW1, 32'd65535);
    write_reg(gcs_pkg::RegW2, 32'd0);
    write_reg(gcs_pkg::RegW3, 32'd65535);
    send_point(32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
    send_point(32'h00008000, 32'h0, 32'h00020000, 1'b0, 1'b0);
    send_point(32'h00010000, 32'hfffe0000, 32'h00000000, 1'b0, 1'b0);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1, 1'b0);
    drain();

    // centre weight zero, limit zero: distinct neighbours skipped, pad copies of the end points still count
    write_reg(gcs_pkg::RegWc, 32'd0);
    write_reg(gcs_pkg::RegLim, 32'd0);
    send_point(32'h00010000, 32'h0, 32'h0, 1'b0, 1'b0);
    send_point(32'h00030000, 32'h0, 32'h0, 1'b1, 1'b0);
    drain();

    write_reg(gcs_pkg::RegPass, 32'd0);
    write_reg(gcs_pkg::RegLim, 32'hffffffff);
    write_reg(gcs_pkg::RegZOnly, 32'd0);
    send_point(32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f, 1'b0, 1'b0);
    send_point(32'hedcba987, 32'h6543210f, 32'hf0f0f0f0, 1'b1, 1'b0);
    drain();

    // overflow: 66 points into a 64-entry store, single pass
    write_reg(gcs_pkg::RegPass, 32'd1);
    write_reg(gcs_pkg::RegLimEn, 32'd0);
    write_reg(gcs_pkg::RegWc, 32'd26000);
    send_curve(66, 2);
    drain();

    // long receiver hold while points keep arriving
    write_reg(gcs_pkg::RegPass, 32'd1);
    long_hold = 1'b1;
    fork
      begin
        send_curve(5, 1);
        send_curve(4, 2);
      end
      begin
        repeat (3000) @(posedge clk);
        long_hold = 1'b0;
      end
    join
    drain();

    // random phases: many short curves, the odd long one or overflow
    while (items_sent < 370) begin
      random_config(1'b1);
      stall_free = ($urandom_range(0, 4) == 0);
      for (int c = 0; c < 3 && items_sent < 370; c++) begin
        case ($urandom_range(0, 9))
          0: len = $urandom_range(60, 66);
          1, 2: len = $urandom_range(1, 3);
          default: len = $urandom_range(4, 14);
        endcase
        if (len > 20 && cur_passes > 2) len = 12;
        send_curve(len, $urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0) drain();
      end
      drain();
    end
    stall_free = 1'b0;

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("gaussian_curve_smoother_3d verification clean");
    end else begin
      $display("gaussian_curve_smoother_3d verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
